// File: hw/rtl/lag_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lag_pkg: shared types and constants of the Langton's ant grid stepper
// Grid sizes, item and result formats, ant state, headings and controller
// states used by the RAM, the ant register file and the core.
// ----------------------------------------------------------------------------
package lag_pkg;

   // Grid sides are powers of two, given by their logarithm (3..8).
   localparam int ZONES       = 4;
   localparam int GRID_W_LOG2 = 6;
   localparam int GRID_H_LOG2 = 6;
   localparam int GRID_W      = 1 << GRID_W_LOG2;
   localparam int GRID_H      = 1 << GRID_H_LOG2;
   localparam int ANT_START   = 32;

   localparam int COL_W     = GRID_W_LOG2;
   localparam int ROW_W     = GRID_H_LOG2;
   localparam int ZONE_AW   = (ZONES > 1) ? $clog2(ZONES) : 1;
   localparam int RAM_AW    = ZONE_AW + ROW_W;
   localparam int RAM_DEPTH = ZONES * GRID_H;

   // Coordinates run from -1 to the grid size and must also hold the start point.
   localparam int COORD_MAG = (GRID_W_LOG2 > GRID_H_LOG2) ?
                              ((GRID_W_LOG2 > 6) ? GRID_W_LOG2 : 6) :
                              ((GRID_H_LOG2 > 6) ? GRID_H_LOG2 : 6);
   localparam int COORD_W   = COORD_MAG + 2;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic [ZONE_AW-1:0]        zone_idx_type;
   typedef logic [RAM_AW-1:0]         ram_addr_type;
   typedef logic [GRID_W-1:0]         grid_row_type;

   localparam coord_type COORD_ZERO  = coord_type'(0);
   localparam coord_type COORD_ONE   = coord_type'(1);
   localparam coord_type COL_LIMIT   = coord_type'(GRID_W);
   localparam coord_type ROW_LIMIT   = coord_type'(GRID_H);
   localparam coord_type COL_LAST    = coord_type'(GRID_W - 1);
   localparam coord_type ROW_LAST    = coord_type'(GRID_H - 1);
   localparam coord_type COORD_START = coord_type'(ANT_START);

   localparam logic KIND_STEP  = 1'b0;
   localparam logic KIND_PROBE = 1'b1;

   typedef enum logic [1:0] {
      DIR_NORTH,
      DIR_EAST,
      DIR_SOUTH,
      DIR_WEST
   } dir_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC
   } state_type;

   typedef struct packed {
      logic       kind;
      logic [1:0] zone;
      logic [5:0] column;
      logic [5:0] row_shift;
   } req_type;

   typedef struct packed {
      logic              cell_res;
      logic signed [7:0] ant_x;
      logic signed [7:0] ant_y;
      logic [1:0]        ant_dir;
   } rsp_type;

   typedef struct packed {
      coord_type col;
      coord_type row;
      dir_type   dir;
   } ant_type;

   typedef struct packed {
      logic         en;
      zone_idx_type zone;
      ant_type      ant;
   } ant_wr_type;

   // Two's complement view of a coordinate in the 8-bit result field.
   function automatic logic signed [7:0] to_out8(coord_type c);
      logic signed [31:0] t;
      t = 32'(c);
      return t[7:0];
   endfunction

endpackage
`default_nettype wire

// File: hw/rtl/langton_ant_grid_stepper_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// langton_ant_grid_stepper_core: one Langton's ant per zone on a binary grid
// Step items turn, flip and move or wrap the zone's ant; probes read one cell.
// ----------------------------------------------------------------------------
//
//   channel   ports                          direction   payload
//   request   req_valid req_stall req_data   in          lag_pkg::req_type
//   response  rsp_valid rsp_stall rsp_data   out         lag_pkg::rsp_type
//
// Each item goes through two steps: its grid row is read from the row RAM as
// it is taken, then the ant is updated and the row written back; a new item
// waits until the last is through. After reset a clearing pass writes all
// ZONES*GRID_H = 256 rows white, one row per cycle, with req_stall held high.
// A stalled response holds the next item in its update cycle until the
// output register frees up.
//
module langton_ant_grid_stepper_core (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire lag_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output lag_pkg::rsp_type      rsp_data
);
   import lag_pkg::*;

   state_type    state_ff, state_in;
   ram_addr_type clr_addr_ff, clr_addr_in;
   logic         kind_ff;
   zone_idx_type zone_ff;
   logic [COL_W-1:0] bit_ff;
   ram_addr_type addr_ff;
   ant_type      ant_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_type      rsp_data_ff, rsp_data_in;

   logic         accept;
   logic         go;
   logic [4:0]   zone_ext;
   zone_idx_type zone_idx;
   ant_type      rd_ant;
   logic [8:0]   col_ext;
   logic [COL_W-1:0] probe_col;
   logic [8:0]   probe_sum;
   logic [ROW_W-1:0] probe_row;
   logic [ROW_W-1:0] sel_row;
   logic [COL_W-1:0] sel_bit;
   ram_addr_type rd_addr;

   grid_row_type rd_row;
   grid_row_type wr_row;
   logic         cur_cell;
   logic         in_grid;
   ant_type      ant_next;
   ant_wr_type   ant_wr;

   logic         ram_we;
   ram_addr_type ram_waddr;
   grid_row_type ram_wdata;

   // Request side decode.
   always_comb begin
      zone_ext  = 5'(req_data.zone);
      zone_idx  = (zone_ext < 5'(ZONES)) ? zone_ext[ZONE_AW-1:0] : '0;
      col_ext   = 9'(req_data.column);
      probe_col = col_ext[COL_W-1:0];
      probe_sum = 9'(probe_col) + 9'(req_data.row_shift);
      probe_row = probe_sum[ROW_W-1:0];
      if (req_data.kind == KIND_PROBE) begin
         sel_row = probe_row;
         sel_bit = probe_col;
      end else begin
         sel_row = rd_ant.row[ROW_W-1:0];
         sel_bit = rd_ant.col[COL_W-1:0];
      end
      rd_addr = {zone_idx, sel_row};
   end

   assign accept = req_valid && !req_stall;

   lag_ant_file u_ant_file (
      .clock   (clock),
      .reset   (reset),
      .rd_zone (zone_idx),
      .rd_ant  (rd_ant),
      .wr      (ant_wr)
   );

   lag_row_ram #(
      .WIDTH (GRID_W),
      .DEPTH (RAM_DEPTH),
      .AW    (RAM_AW)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (rd_row)
   );

   // Update datapath, valid in the execute cycle.
   always_comb begin
      cur_cell = rd_row[bit_ff];
      in_grid  = (ant_ff.col >= COORD_ZERO) && (ant_ff.col < COL_LIMIT) &&
                 (ant_ff.row >= COORD_ZERO) && (ant_ff.row < ROW_LIMIT);
      wr_row          = rd_row;
      wr_row[bit_ff]  = ~cur_cell;
      ant_next        = ant_ff;
      if (!in_grid) begin
         // An ant that walked off the edge only wraps back this step.
         if (ant_ff.col < COORD_ZERO) begin
            ant_next.col = COL_LAST;
         end else if (ant_ff.col >= COL_LIMIT) begin
            ant_next.col = COORD_ZERO;
         end
         if (ant_ff.row < COORD_ZERO) begin
            ant_next.row = ROW_LAST;
         end else if (ant_ff.row >= ROW_LIMIT) begin
            ant_next.row = COORD_ZERO;
         end
      end else begin
         if (cur_cell) begin
            ant_next.dir = dir_type'(2'(ant_ff.dir + 2'd1));
         end else begin
            ant_next.dir = dir_type'(2'(ant_ff.dir + 2'd3));
         end
         case (ant_next.dir)
            DIR_NORTH: ant_next.row = coord_type'(ant_ff.row - COORD_ONE);
            DIR_EAST:  ant_next.col = coord_type'(ant_ff.col + COORD_ONE);
            DIR_SOUTH: ant_next.row = coord_type'(ant_ff.row + COORD_ONE);
            default:   ant_next.col = coord_type'(ant_ff.col - COORD_ONE);
         endcase
      end
   end

   // Next state.
   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = ram_addr_type'(clr_addr_ff + 1'b1);
            if (clr_addr_ff == ram_addr_type'(RAM_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (go) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // Outputs of the controller.
   always_comb begin
      req_stall  = (state_ff != ST_IDLE);
      go         = (state_ff == ST_EXEC) && (!rsp_valid_ff || !rsp_stall);
      ram_we     = 1'b0;
      ram_waddr  = addr_ff;
      ram_wdata  = wr_row;
      ant_wr.en   = 1'b0;
      ant_wr.zone = zone_ff;
      ant_wr.ant  = ant_next;
      case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_ff;
            ram_wdata = '1;
         end
         ST_EXEC: begin
            if (go && kind_ff == KIND_STEP) begin
               ram_we    = in_grid;
               ant_wr.en = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // Response register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (go) begin
         rsp_valid_in = 1'b1;
         if (kind_ff == KIND_PROBE) begin
            rsp_data_in.cell_res = cur_cell;
            rsp_data_in.ant_x    = to_out8(ant_ff.col);
            rsp_data_in.ant_y    = to_out8(ant_ff.row);
            rsp_data_in.ant_dir  = ant_ff.dir;
         end else begin
            rsp_data_in.cell_res = 1'b0;
            rsp_data_in.ant_x    = to_out8(ant_next.col);
            rsp_data_in.ant_y    = to_out8(ant_next.row);
            rsp_data_in.ant_dir  = ant_next.dir;
         end
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (accept) begin
         kind_ff <= req_data.kind;
         zone_ff <= zone_idx;
         bit_ff  <= sel_bit;
         addr_ff <= rd_addr;
         ant_ff  <= rd_ant;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

// File: hw/rtl/lag_row_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lag_row_ram: simple dual-port synchronous RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module lag_row_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256,
   parameter int AW    = 8
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: hw/rtl/lag_ant_file.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lag_ant_file: per-zone ant position and heading
// Holds one ant per zone in flip-flops, read at one zone and written at one.
// ----------------------------------------------------------------------------
module lag_ant_file (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire lag_pkg::zone_idx_type rd_zone,
   output lag_pkg::ant_type           rd_ant,
   input  wire lag_pkg::ant_wr_type   wr
);
   import lag_pkg::*;

   ant_type ant_ff [ZONES];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int z = 0; z < ZONES; z++) begin
            ant_ff[z].col <= COORD_START;
            ant_ff[z].row <= COORD_START;
            ant_ff[z].dir <= DIR_NORTH;
         end
      end else if (wr.en) begin
         ant_ff[wr.zone] <= wr.ant;
      end
   end

   assign rd_ant = ant_ff[rd_zone];

endmodule
`default_nettype wire

// File: hw/rtl/lag_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lag_checker: port-level checks of the grid stepper core
// Watches both channels and is bound into the grid stepper core.
// ----------------------------------------------------------------------------
module lag_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_stall,
   input wire lag_pkg::req_type req_data,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire lag_pkg::rsp_type rsp_data
);

   // A stalled response stays offered and unchanged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // Each transfer is followed by a stall while the row is updated.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken during update cycle");

   // The grid clearing pass keeps the input closed right after reset.
   assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("request open during clearing pass");

   // A fresh response follows a request transfer through the execute state and the response register.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
      else $error("response without a matching request");

endmodule

bind langton_ant_grid_stepper_core lag_checker u_lag_checker (.*);
`default_nettype wire

// File: dv/lag_tb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lag_tb_pkg: scoreboard for the Langton's ant grid stepper testbench
// Keeps its own copy of every zone's grid and ant, works out the result of
// each accepted item and compares the results leaving the core in order.
// ----------------------------------------------------------------------------
package lag_tb_pkg;
   import lag_pkg::*;

   class ant_scoreboard;
      bit        cells[ZONES][GRID_H][GRID_W];
      int        col[ZONES];
      int        row[ZONES];
      dir_type   heading[ZONES];
      rsp_type   predicted_rsp_q[$];
      int        errors;
      int        checked;
      int        steps;
      int        probes;
      int        wraps;

      function new();
         foreach (cells[z, y, x]) cells[z][y][x] = 1'b1;
         for (int z = 0; z < ZONES; z++) begin
            col[z]     = ANT_START;
            row[z]     = ANT_START;
            heading[z] = DIR_NORTH;
         end
         errors  = 0;
         checked = 0;
         steps   = 0;
         probes  = 0;
         wraps   = 0;
      endfunction

      function int ant_col(int z);
         return col[z];
      endfunction

      function int ant_row(int z);
         return row[z];
      endfunction

      function int unsigned outstanding();
         return predicted_rsp_q.size();
      endfunction

      // Advances the model by one accepted request and queues its result.
      function void note_request(req_type r);
         int          z;
         int          x;
         int          y;
         logic [5:0]  probe_row;
         rsp_type     res;
         z   = (int'(r.zone) < ZONES) ? int'(r.zone) : 0;
         res = '0;
         if (r.kind == KIND_STEP) begin
            steps++;
            x = col[z];
            y = row[z];
            if (x < 0 || x >= GRID_W || y < 0 || y >= GRID_H) begin
               // An ant that walked off the edge only comes back in on this step.
               wraps++;
               col[z] = (x + GRID_W) % GRID_W;
               row[z] = (y + GRID_H) % GRID_H;
            end else begin
               if (cells[z][y][x]) begin
                  heading[z]     = dir_type'(heading[z] + 2'd1);
                  cells[z][y][x] = 1'b0;
               end else begin
                  heading[z]     = dir_type'(heading[z] + 2'd3);
                  cells[z][y][x] = 1'b1;
               end
               case (heading[z])
                  DIR_NORTH: row[z] = y - 1;
                  DIR_EAST:  col[z] = x + 1;
                  DIR_SOUTH: row[z] = y + 1;
                  default:   col[z] = x - 1;
               endcase
            end
         end else begin
            probes++;
            probe_row    = r.column + r.row_shift;
            res.cell_res = cells[z][probe_row % GRID_H][r.column % GRID_W];
         end
         res.ant_x   = col[z][7:0];
         res.ant_y   = row[z][7:0];
         res.ant_dir = heading[z];
         predicted_rsp_q.push_back(res);
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (predicted_rsp_q.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("ERROR: unexpected result cell=%0d x=%0d y=%0d dir=%0d",
                        got.cell_res, got.ant_x, got.ant_y, got.ant_dir);
            return;
         end
         want = predicted_rsp_q.pop_front();
         checked++;
         if (got.cell_res !== want.cell_res || got.ant_x !== want.ant_x ||
             got.ant_y !== want.ant_y || got.ant_dir !== want.ant_dir) begin
            errors++;
            if (errors <= 10)
               $display({"ERROR: result %0d: expected cell=%0d x=%0d y=%0d dir=%0d,",
                         " got cell=%0d x=%0d y=%0d dir=%0d"},
                        checked, want.cell_res, want.ant_x, want.ant_y, want.ant_dir,
                        got.cell_res, got.ant_x, got.ant_y, got.ant_dir);
         end
      endfunction
   endclass

endpackage
`default_nettype wire

// File: dv/tb_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top: testbench of the Langton's ant grid stepper core
// Drives directed and random step and probe transfers under random sender
// gaps and receiver stalls, with runs of steps that let one zone's ant walk,
// and checks every result against the scoreboard's own grid model.
// ----------------------------------------------------------------------------
module tb_top;
   import lag_pkg::*;
   import lag_tb_pkg::*;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b1;
   rsp_type rsp_data;

   int unsigned   send_idle_pct = 26;
   int unsigned   recv_idle_pct = 53;
   ant_scoreboard sb;

   langton_ant_grid_stepper_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Verification failed");
      $finish;
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_response(rsp_data);
   end

   function automatic req_type make_req(logic kind, int zone, int column, int shift);
      req_type r;
      r.kind      = kind;
      r.zone      = 2'(zone);
      r.column    = 6'(column);
      r.row_shift = 6'(shift);
      return r;
   endfunction

   // Mostly steps and probes around the ant, the rest probes anywhere.
   function automatic req_type random_req();
      req_type    r;
      int         pick;
      int         z;
      logic [5:0] c;
      r.kind      = 1'($urandom);
      r.zone      = 2'($urandom);
      r.column    = 6'($urandom);
      r.row_shift = 6'($urandom);
      pick = $urandom_range(99);
      if (pick < 55) begin
         r.kind = KIND_STEP;
      end else begin
         r.kind = KIND_PROBE;
         if (pick < 85) begin
            z           = int'(r.zone);
            c           = 6'(sb.ant_col(z) + int'($urandom_range(2)) - 1);
            r.column    = c;
            r.row_shift = 6'(sb.ant_row(z) + int'($urandom_range(2)) - 1) - c;
         end
      end
      return r;
   endfunction

   // Entered just after a falling edge; returns just after a falling edge.
   task automatic send_req(input req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      sb.note_request(item);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic run_mixed(input int count);
      for (int i = 0; i < count; i++) send_req(random_req());
   endtask

   // A run of steps on one zone lets its ant build up a trail of its own,
   // with a few random items mixed in.
   task automatic run_walk(input int zone, input int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(99) < 92)
            send_req(make_req(KIND_STEP, zone, $urandom, $urandom));
         else
            send_req(random_req());
      end
   endtask

   initial begin
      int walk_zone;
      sb = new();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Probes at the corners (one beside a corner) on a fresh grid in every zone.
      send_req(make_req(KIND_PROBE, 0, 0, 0));
      send_req(make_req(KIND_PROBE, 1, 63, 63));
      send_req(make_req(KIND_PROBE, 2, 63, 0));
      send_req(make_req(KIND_PROBE, 3, 0, 63));
      // Four right turns bring the ant back to its start cell, now black,
      // so the fifth step turns left.
      repeat (5) send_req(make_req(KIND_STEP, 1, 0, 0));
      send_req(make_req(KIND_PROBE, 1, 32, 0));
      send_req(make_req(KIND_PROBE, 1, 33, 63));
      send_req(make_req(KIND_PROBE, 0, 32, 0));
      send_req(make_req(KIND_STEP, 3, 63, 63));
      send_req(make_req(KIND_STEP, 0, 63, 63));
      send_req(make_req(KIND_PROBE, 3, 32, 0));
      send_req(make_req(KIND_PROBE, 2, 31, 1));
      send_req(make_req(KIND_PROBE, 0, 63, 63));
      send_req(make_req(KIND_STEP, 2, 0, 0));
      send_req(make_req(KIND_PROBE, 2, 32, 0));
      drain_results();

      run_mixed(150);
      walk_zone = $urandom_range(ZONES - 1);
      run_walk(walk_zone, 120);
      drain_results();

      send_idle_pct = 53;
      recv_idle_pct = 26;
      run_mixed(150);
      run_walk((walk_zone + 1 + $urandom_range(ZONES - 2)) % ZONES, 120);
      drain_results();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_mixed(250);

      req_valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (16) @(posedge clock);

      $display("Checked %0d results: %0d steps, %0d of them edge wraps, and %0d probes.",
               sb.checked, sb.steps, sb.wraps, sb.probes);
      $display("Traffic ran with heavy receiver stalls, then heavy sender gaps, then none.");
      if (sb.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("%0d result errors in total.", sb.errors);
         $display("Verification failed");
      end
      $finish;
   end

endmodule
`default_nettype wire
